/* rtl/core/tlb_lookup_fifo_lru_defines.svh */
// assertion macros for the tlb lookup block
`ifndef TLB_LOOKUP_FIFO_LRU_DEFINES_SVH
`define TLB_LOOKUP_FIFO_LRU_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define TLBL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define TLBL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/tlbl_pkg.sv */
// shared types and constants for the tlb lookup block
package tlbl_pkg;

   localparam int ADDR_W     = 32;
   localparam int PID_W      = 16;
   localparam int FRAME_W    = 20;
   localparam int STATUS_W   = 2;
   localparam int SHIFT_W    = 5;
   localparam int LIMIT_W    = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [STATUS_W-1:0] ST_HIT    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FILLED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FAULT  = 2'd3;

   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_FILL   = 1'b1;

   localparam logic MODE_FIFO = 1'b0;
   localparam logic MODE_LRU  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_PAGE_LOG2      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REPLACE_MODE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ENTRIES_IN_USE = 2'd2;

   typedef struct packed {
      logic evict;
      logic lru_move;
      logic load_en;
   } cell_ctl_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  page;
      logic [PID_W-1:0]   pid;
      logic [FRAME_W-1:0] frame;
   } entry_type;

endpackage

/* rtl/core/tlb_lookup_fifo_lru.sv */
// top level of the fully associative tlb with fifo or lru ordering
// One word is taken per cycle and busy is never raised; its result goes through the s1_ and
// rsp_ registers, shows on the rsp_ ports for exactly one cycle and cannot be held off. The
// first stage latches the word and forms the page number with a shift; the second stage
// searches the row of MAX_ENTRIES entry cells, picks the oldest match and shifts the age
// order in the same cycle, so the next word always sees the updated table. Registers are
// written via the always-ready csr_ channel, by the user only while no word is in flight; unchecked.
`include "tlb_lookup_fifo_lru_defines.svh"

module tlb_lookup_fifo_lru #(
   parameter int MAX_ENTRIES = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_action,
   input  logic [tlbl_pkg::ADDR_W-1:0]      req_logical_address,
   input  logic [tlbl_pkg::PID_W-1:0]       req_process_id,
   input  logic [tlbl_pkg::FRAME_W-1:0]     req_reply_frame,
   input  logic                             req_reply_ok,
   output logic                             rsp_valid,
   output logic [tlbl_pkg::STATUS_W-1:0]    rsp_status,
   output logic [tlbl_pkg::FRAME_W-1:0]     rsp_frame_number,
   output logic [tlbl_pkg::ADDR_W-1:0]      rsp_page_number,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tlbl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tlbl_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);

   logic [tlbl_pkg::SHIFT_W-1:0]  page_log2_ff;
   logic                          mode_ff;
   logic [tlbl_pkg::LIMIT_W-1:0]  limit_ff;

   logic                          s1_valid_ff;
   logic                          s1_action_ff;
   logic [tlbl_pkg::ADDR_W-1:0]   s1_page_ff;
   logic [tlbl_pkg::PID_W-1:0]    s1_pid_ff;
   logic [tlbl_pkg::FRAME_W-1:0]  s1_frame_ff;
   logic                          s1_ok_ff;

   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 count_in;

   logic                          rsp_valid_ff;
   logic [tlbl_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [tlbl_pkg::STATUS_W-1:0] rsp_status_in;
   logic [tlbl_pkg::FRAME_W-1:0]  rsp_frame_ff;
   logic [tlbl_pkg::FRAME_W-1:0]  rsp_frame_in;
   logic [tlbl_pkg::ADDR_W-1:0]   rsp_page_ff;

   logic                          accept;
   logic [31:0]                   cap;
   logic                          full;
   logic                          tlb_on;
   logic                          is_lookup;
   logic                          is_fill_ok;
   logic                          hit;
   logic [tlbl_pkg::FRAME_W-1:0]  hit_frame;
   logic                          lru_move;
   logic                          append;
   logic                          evict;
   logic [CW-1:0]                 load_slot;
   logic [tlbl_pkg::FRAME_W-1:0]  new_frame;
   tlbl_pkg::cell_ctl_type        ctl;

   tlbl_pkg::entry_type           cell_entry [MAX_ENTRIES];
   logic [MAX_ENTRIES:0]          seen;
   logic [tlbl_pkg::FRAME_W-1:0]  fchain [MAX_ENTRIES+1];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         page_log2_ff <= tlbl_pkg::SHIFT_W'(12);
         mode_ff      <= tlbl_pkg::MODE_FIFO;
         limit_ff     <= tlbl_pkg::LIMIT_W'(32);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tlbl_pkg::REG_PAGE_LOG2: begin
               page_log2_ff <= csr_wdata[tlbl_pkg::SHIFT_W-1:0];
            end
            tlbl_pkg::REG_REPLACE_MODE: begin
               mode_ff <= csr_wdata[0];
            end
            tlbl_pkg::REG_ENTRIES_IN_USE: begin
               limit_ff <= csr_wdata[tlbl_pkg::LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // stage one: latch word and form page number
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff <= req_action;
         s1_page_ff   <= req_logical_address >> page_log2_ff;
         s1_pid_ff    <= req_process_id;
         s1_frame_ff  <= req_reply_frame;
         s1_ok_ff     <= req_reply_ok;
      end
   end

   // row of entry cells, slot zero oldest
   assign seen[0]   = 1'b0;
   assign fchain[0] = '0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_row
      tlbl_pkg::entry_type nbr;
      if (i == MAX_ENTRIES - 1) begin : g_last
         assign nbr = '0;
      end else begin : g_mid
         assign nbr = cell_entry[i+1];
      end
      tlbl_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .load_slot  (load_slot),
         .key_page   (s1_page_ff),
         .key_pid    (s1_pid_ff),
         .new_frame  (new_frame),
         .next_entry (nbr),
         .entry      (cell_entry[i]),
         .seen_in    (seen[i]),
         .frame_in   (fchain[i]),
         .seen_out   (seen[i+1]),
         .frame_out  (fchain[i+1])
      );
   end

   // stage two: decide, reorder, respond
   always_comb begin
      hit        = seen[MAX_ENTRIES];
      hit_frame  = fchain[MAX_ENTRIES];
      cap        = (32'(limit_ff) > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : 32'(limit_ff);
      full       = 32'(count_ff) >= cap;
      tlb_on     = limit_ff != '0;
      is_lookup  = s1_valid_ff && (s1_action_ff == tlbl_pkg::ACT_LOOKUP);
      is_fill_ok = s1_valid_ff && (s1_action_ff == tlbl_pkg::ACT_FILL) && s1_ok_ff;
      lru_move   = is_lookup && hit && (mode_ff == tlbl_pkg::MODE_LRU);
      append     = is_fill_ok && tlb_on && !full;
      evict      = is_fill_ok && tlb_on && full && (count_ff != '0);
      load_slot  = append ? count_ff : count_ff - CW'(1);
      new_frame  = lru_move ? hit_frame : s1_frame_ff;
      count_in   = append ? count_ff + CW'(1) : count_ff;

      ctl.evict    = evict;
      ctl.lru_move = lru_move;
      ctl.load_en  = lru_move || append || evict;

      if (s1_action_ff == tlbl_pkg::ACT_LOOKUP) begin
         rsp_status_in = hit ? tlbl_pkg::ST_HIT : tlbl_pkg::ST_MISS;
         rsp_frame_in  = hit ? hit_frame : '0;
      end else begin
         rsp_status_in = s1_ok_ff ? tlbl_pkg::ST_FILLED : tlbl_pkg::ST_FAULT;
         rsp_frame_in  = s1_ok_ff ? s1_frame_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_status_ff <= rsp_status_in;
         rsp_frame_ff  <= rsp_frame_in;
         rsp_page_ff   <= s1_page_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_frame_number = rsp_frame_ff;
   assign rsp_page_number  = rsp_page_ff;

   `TLBL_ASSERT_NEXT(a_accept_to_stage, accept, s1_valid_ff, "accepted word lost before lookup")
   `TLBL_ASSERT_NEXT(a_stage_to_rsp, s1_valid_ff, rsp_valid_ff, "looked-up word gave no result")
   `TLBL_ASSERT_NEXT(a_append_grows, append, count_ff == $past(count_ff) + CW'(1),
      "append did not grow occupancy")
   `TLBL_ASSERT_NEXT(a_no_shrink, 1'b1, count_ff >= $past(count_ff), "occupancy shrank")
   `TLBL_ASSERT_NOW(a_count_cap, 1'b1, 32'(count_ff) <= 32'(MAX_ENTRIES),
      "occupancy above capacity")

endmodule

/* rtl/core/tlbl_cell.sv */
// one age-ordered tlb entry with its compare and shift logic
module tlbl_cell #(
   parameter int IDX = 0,
   parameter int CW  = 6
) (
   input  logic                          clock,
   input  tlbl_pkg::cell_ctl_type        ctl,
   input  logic [CW-1:0]                 count,
   input  logic [CW-1:0]                 load_slot,
   input  logic [tlbl_pkg::ADDR_W-1:0]   key_page,
   input  logic [tlbl_pkg::PID_W-1:0]    key_pid,
   input  logic [tlbl_pkg::FRAME_W-1:0]  new_frame,
   input  tlbl_pkg::entry_type           next_entry,
   output tlbl_pkg::entry_type           entry,
   input  logic                          seen_in,
   input  logic [tlbl_pkg::FRAME_W-1:0]  frame_in,
   output logic                          seen_out,
   output logic [tlbl_pkg::FRAME_W-1:0]  frame_out
);

   tlbl_pkg::entry_type entry_ff;
   tlbl_pkg::entry_type entry_in;
   logic occupied;
   logic has_next;
   logic match;
   logic first;
   logic shift;
   logic load;

   always_comb begin
      occupied  = CW'(IDX) < count;
      has_next  = CW'(IDX + 1) < count;
      match     = occupied && (entry_ff.page == key_page) && (entry_ff.pid == key_pid);
      first     = match && !seen_in;
      seen_out  = seen_in || match;
      frame_out = frame_in | (first ? entry_ff.frame : '0);
      // newer neighbors close the gap toward slot zero
      shift     = has_next && (ctl.evict || (ctl.lru_move && seen_out));
      load      = ctl.load_en && (load_slot == CW'(IDX));
      if (load) begin
         entry_in.page  = key_page;
         entry_in.pid   = key_pid;
         entry_in.frame = new_frame;
      end else if (shift) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* test/tlb_lookup_fifo_lru_test.sv */
// self-checking testbench for the fifo/lru tlb lookup block: shadow table, driver tasks, checks
`timescale 1ns / 1ps

typedef struct {
   logic [tlbl_pkg::STATUS_W-1:0] status;
   logic [tlbl_pkg::FRAME_W-1:0]  frame;
   logic [tlbl_pkg::ADDR_W-1:0]   page;
} translation_type;

class tlb_shadow_type #(int DEPTH = 32);
   logic [tlbl_pkg::ADDR_W-1:0]  page_at[DEPTH];
   logic [tlbl_pkg::PID_W-1:0]   pid_at[DEPTH];
   logic [tlbl_pkg::FRAME_W-1:0] frame_at[DEPTH];
   int unsigned                  occupied;
   logic [tlbl_pkg::SHIFT_W-1:0] page_shift;
   logic                         lru_on;
   logic [tlbl_pkg::LIMIT_W-1:0] enabled;
   translation_type              pending[$];
   int unsigned                  errors;

   function new();
      for (int i = 0; i < DEPTH; i++) begin
         page_at[i] = '0;
         pid_at[i] = '0;
         frame_at[i] = '0;
      end
      occupied = 0;
      page_shift = tlbl_pkg::SHIFT_W'(12);
      lru_on = tlbl_pkg::MODE_FIFO;
      enabled = tlbl_pkg::LIMIT_W'(32);
      errors = 0;
   endfunction

   function void write_reg(logic [tlbl_pkg::CSR_IDX_W-1:0] idx,
                           logic [tlbl_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         tlbl_pkg::REG_PAGE_LOG2: page_shift = data[tlbl_pkg::SHIFT_W-1:0];
         tlbl_pkg::REG_REPLACE_MODE: lru_on = data[0];
         tlbl_pkg::REG_ENTRIES_IN_USE: enabled = data[tlbl_pkg::LIMIT_W-1:0];
         default: ;
      endcase
   endfunction

   // move slots above from one place toward the old end
   function void close_slot(int unsigned from);
      for (int unsigned i = from; i + 1 < occupied; i++) begin
         page_at[i] = page_at[i+1];
         pid_at[i] = pid_at[i+1];
         frame_at[i] = frame_at[i+1];
      end
   endfunction

   function void put_slot(int unsigned slot, logic [tlbl_pkg::ADDR_W-1:0] page,
                          logic [tlbl_pkg::PID_W-1:0] pid,
                          logic [tlbl_pkg::FRAME_W-1:0] frame);
      page_at[slot] = page;
      pid_at[slot] = pid;
      frame_at[slot] = frame;
   endfunction

   function void note_word(logic act, logic [tlbl_pkg::ADDR_W-1:0] addr,
                           logic [tlbl_pkg::PID_W-1:0] pid,
                           logic [tlbl_pkg::FRAME_W-1:0] rframe, logic ok);
      translation_type t;
      int unsigned     limit;
      int unsigned     at;
      bit              hit;
      t.page = addr >> page_shift;
      t.frame = '0;
      limit = (enabled > DEPTH) ? DEPTH : enabled;
      hit = 0;
      at = 0;
      if (act == tlbl_pkg::ACT_LOOKUP) begin
         for (int unsigned i = 0; i < occupied; i++) begin
            if (!hit && page_at[i] == t.page && pid_at[i] == pid) begin
               hit = 1;
               at = i;
            end
         end
         if (hit) begin
            t.status = tlbl_pkg::ST_HIT;
            t.frame = frame_at[at];
            if (lru_on == tlbl_pkg::MODE_LRU) begin
               close_slot(at);
               put_slot(occupied - 1, t.page, pid, t.frame);
            end
         end else begin
            t.status = tlbl_pkg::ST_MISS;
         end
      end else if (!ok) begin
         t.status = tlbl_pkg::ST_FAULT;
      end else begin
         t.status = tlbl_pkg::ST_FILLED;
         t.frame = rframe;
         if (enabled != 0) begin
            if (occupied < limit) begin
               put_slot(occupied, t.page, pid, rframe);
               occupied++;
            end else if (occupied > 0) begin
               close_slot(0);
               put_slot(occupied - 1, t.page, pid, rframe);
            end
         end
      end
      pending.push_back(t);
   endfunction

   function void check_word(logic [tlbl_pkg::STATUS_W-1:0] status,
                            logic [tlbl_pkg::FRAME_W-1:0] frame,
                            logic [tlbl_pkg::ADDR_W-1:0] page);
      translation_type t;
      if (pending.size() == 0) begin
         $display("%0t unexpected word: status %0d frame %h page %h", $time, status, frame, page);
         errors++;
      end else begin
         t = pending.pop_front();
         if (status !== t.status) begin
            $display("%0t status: expected %0d actual %0d", $time, t.status, status);
            errors++;
         end
         if (frame !== t.frame) begin
            $display("%0t frame: expected %h actual %h", $time, t.frame, frame);
            errors++;
         end
         if (page !== t.page) begin
            $display("%0t page: expected %h actual %h", $time, t.page, page);
            errors++;
         end
      end
   endfunction
endclass

module tlb_lookup_fifo_lru_test;
   localparam int TLB_DEPTH   = 32;
   localparam int PHASES      = 8;
   localparam int PHASE_WORDS = 105;
   localparam int POOL        = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [tlbl_pkg::CSR_IDX_W-1:0] REG_NONE = 2'd3;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic                            req_action;
   logic [tlbl_pkg::ADDR_W-1:0]     req_logical_address;
   logic [tlbl_pkg::PID_W-1:0]      req_process_id;
   logic [tlbl_pkg::FRAME_W-1:0]    req_reply_frame;
   logic                            req_reply_ok;
   logic                            rsp_valid;
   logic [tlbl_pkg::STATUS_W-1:0]   rsp_status;
   logic [tlbl_pkg::FRAME_W-1:0]    rsp_frame_number;
   logic [tlbl_pkg::ADDR_W-1:0]     rsp_page_number;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [tlbl_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [tlbl_pkg::CSR_DATA_W-1:0] csr_wdata;

   tlb_shadow_type #(TLB_DEPTH)   shadow;
   int unsigned                   cycles = 0;
   bit                            idle_on;
   logic [tlbl_pkg::ADDR_W-1:0]   addr_pool[POOL];
   logic [tlbl_pkg::PID_W-1:0]    pid_pool[4];

   int          shift_set[PHASES] = '{12, 0, 31, 5, 20, 12, 8, 16};
   logic        mode_set[PHASES]  = '{tlbl_pkg::MODE_LRU, tlbl_pkg::MODE_FIFO,
                                      tlbl_pkg::MODE_LRU, tlbl_pkg::MODE_FIFO,
                                      tlbl_pkg::MODE_LRU, tlbl_pkg::MODE_LRU,
                                      tlbl_pkg::MODE_FIFO, tlbl_pkg::MODE_LRU};
   int          use_set[PHASES]   = '{32, 3, 1, 0, 63, 4, 2, 32};

   tlb_lookup_fifo_lru #(.MAX_ENTRIES(TLB_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_logical_address(req_logical_address),
      .req_process_id(req_process_id),
      .req_reply_frame(req_reply_frame),
      .req_reply_ok(req_reply_ok),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_frame_number(rsp_frame_number),
      .rsp_page_number(rsp_page_number),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tlb_lookup_fifo_lru: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            shadow.check_word(rsp_status, rsp_frame_number, rsp_page_number);
         if (start && !busy)
            shadow.note_word(req_action, req_logical_address, req_process_id,
                             req_reply_frame, req_reply_ok);
         if (csr_valid && csr_ready)
            shadow.write_reg(csr_index, csr_wdata);
      end
   end

   task automatic send_word(logic act, logic [tlbl_pkg::ADDR_W-1:0] addr,
                            logic [tlbl_pkg::PID_W-1:0] pid,
                            logic [tlbl_pkg::FRAME_W-1:0] frame, logic ok);
      while (idle_on && $urandom_range(99) < 22) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_logical_address <= addr;
      req_process_id <= pid;
      req_reply_frame <= frame;
      req_reply_ok <= ok;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (shadow.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [tlbl_pkg::CSR_IDX_W-1:0] idx,
                            logic [tlbl_pkg::CSR_DATA_W-1:0] value,
                            logic [tlbl_pkg::CSR_DATA_W-1:0] field_mask);
      logic [tlbl_pkg::CSR_DATA_W-1:0] data;
      data = value;
      if ($urandom_range(3) == 0)
         data = data | (tlbl_pkg::CSR_DATA_W'($urandom) & ~field_mask);
      if (idle_on && $urandom_range(99) < 22) begin
         csr_valid <= 1'b0;
         @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(int shift, logic mode, int in_use);
      write_reg(tlbl_pkg::REG_PAGE_LOG2, tlbl_pkg::CSR_DATA_W'(shift), 32'h1F);
      write_reg(tlbl_pkg::REG_REPLACE_MODE, tlbl_pkg::CSR_DATA_W'(mode), 32'h1);
      write_reg(tlbl_pkg::REG_ENTRIES_IN_USE, tlbl_pkg::CSR_DATA_W'(in_use), 32'h3F);
      csr_valid <= 1'b0;
   endtask

   task automatic random_word();
      int unsigned                 pick;
      int unsigned                 slot;
      logic [tlbl_pkg::ADDR_W-1:0] mask;
      logic [tlbl_pkg::ADDR_W-1:0] addr;
      logic [tlbl_pkg::PID_W-1:0]  pid;
      mask = (32'h1 << shadow.page_shift) - 32'h1;
      pick = $urandom_range(99);
      addr = (addr_pool[$urandom_range(POOL-1)] & ~mask) | ($urandom & mask);
      pid = pid_pool[$urandom_range(3)];
      if (pick < 35 && shadow.occupied > 0) begin
         // lookup of a resident translation
         slot = $urandom_range(shadow.occupied - 1);
         addr = (shadow.page_at[slot] << shadow.page_shift) | ($urandom & mask);
         send_word(tlbl_pkg::ACT_LOOKUP, addr, shadow.pid_at[slot],
                   tlbl_pkg::FRAME_W'($urandom), 1'($urandom));
      end else if (pick < 75) begin
         // miss followed by its memory reply
         send_word(tlbl_pkg::ACT_LOOKUP, addr, pid, tlbl_pkg::FRAME_W'($urandom),
                   1'($urandom));
         send_word(tlbl_pkg::ACT_FILL, addr, pid, tlbl_pkg::FRAME_W'($urandom),
                   $urandom_range(9) != 0);
      end else if (pick < 85) begin
         send_word(tlbl_pkg::ACT_FILL, addr, pid, tlbl_pkg::FRAME_W'($urandom),
                   1'($urandom));
      end else begin
         send_word(1'($urandom), $urandom, tlbl_pkg::PID_W'($urandom),
                   tlbl_pkg::FRAME_W'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      shadow = new();
      reset <= 1'b1;
      start <= 1'b0;
      req_action <= tlbl_pkg::ACT_LOOKUP;
      req_logical_address <= '0;
      req_process_id <= '0;
      req_reply_frame <= '0;
      req_reply_ok <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= tlbl_pkg::REG_PAGE_LOG2;
      csr_wdata <= '0;
      idle_on = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: hits, misses, fault, duplicate and unrequested fills
      send_word(tlbl_pkg::ACT_LOOKUP, 32'h0000_0000, 16'h0000, 20'h00000, 1'b0);
      send_word(tlbl_pkg::ACT_FILL,   32'h0000_0000, 16'h0000, 20'h00000, 1'b1);
      send_word(tlbl_pkg::ACT_LOOKUP, 32'h0000_0FFF, 16'h0000, 20'hFFFFF, 1'b1);
      send_word(tlbl_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 20'h00000, 1'b0);
      send_word(tlbl_pkg::ACT_FILL,   32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF, 1'b0);
      send_word(tlbl_pkg::ACT_FILL,   32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF, 1'b1);
      send_word(tlbl_pkg::ACT_LOOKUP, 32'hFFFF_F000, 16'hFFFF, 20'h00000, 1'b0);
      send_word(tlbl_pkg::ACT_FILL,   32'h0000_0000, 16'h0000, 20'h12345, 1'b1);
      send_word(tlbl_pkg::ACT_LOOKUP, 32'h0000_0000, 16'h0000, 20'h00000, 1'b0);
      send_word(tlbl_pkg::ACT_LOOKUP, 32'h0000_0000, 16'h0001, 20'h00000, 1'b0);
      send_word(tlbl_pkg::ACT_FILL,   32'h1234_5678, 16'h0042, 20'hABCDE, 1'b1);
      drain();

      // no tlb: fills pass through and store nothing
      write_reg(REG_NONE, $urandom, 32'h0);
      configure(0, tlbl_pkg::MODE_FIFO, 0);
      send_word(tlbl_pkg::ACT_FILL,   32'hDEAD_BEEF, 16'h0003, 20'h0F0F0, 1'b1);
      send_word(tlbl_pkg::ACT_LOOKUP, 32'h0000_0000, 16'h0000, 20'h00000, 1'b0);
      send_word(tlbl_pkg::ACT_LOOKUP, 32'hDEAD_BEEF, 16'h0003, 20'h00000, 1'b0);
      drain();

      // limit below occupancy, widest shift, lru refresh
      configure(31, tlbl_pkg::MODE_LRU, 1);
      send_word(tlbl_pkg::ACT_FILL,   32'h8000_0000, 16'h0007, 20'h55555, 1'b1);
      send_word(tlbl_pkg::ACT_LOOKUP, 32'h0000_0000, 16'h0000, 20'h00000, 1'b0);
      send_word(tlbl_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 16'h0007, 20'h00000, 1'b0);
      send_word(tlbl_pkg::ACT_LOOKUP, 32'h7FFF_FFFF, 16'hFFFF, 20'h00000, 1'b0);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         idle_on = (p != PHASES - 1);
         configure(shift_set[p], mode_set[p], use_set[p]);
         for (int i = 0; i < POOL; i++)
            addr_pool[i] = $urandom;
         for (int i = 0; i < 4; i++)
            pid_pool[i] = tlbl_pkg::PID_W'($urandom);
         for (int n = 0; n < PHASE_WORDS; n++)
            random_word();
         drain();
      end

      shadow.errors += shadow.pending.size();
      if (shadow.errors == 0)
         $display("tlb_lookup_fifo_lru: match");
      else
         $display("tlb_lookup_fifo_lru: mismatch");
      $finish;
   end
endmodule
